// File: rtl/brc_pkg.sv
`default_nettype none

package brc_pkg;

   localparam int NUM_PROCESSES = 5;
   localparam int NUM_RESOURCES = 4;
   localparam int COUNT_WIDTH   = 8;

   localparam int FUNC_W      = 3;
   localparam int PIDX_PORT_W = 3;
   localparam int RIDX_PORT_W = 2;
   localparam int FIELD_W     = 8;
   localparam int STATUS_W    = 3;
   localparam int SLOT_W      = 3;
   localparam int ORDER_W     = 24;
   localparam int LEN_W       = 4;

   localparam int PIDX_W = $clog2(NUM_PROCESSES);
   localparam int RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int CNT_W  = $clog2(NUM_PROCESSES + 1);
   localparam int CMP_W  = ((COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W) + 2;
   localparam int WORK_W = COUNT_WIDTH + $clog2(NUM_PROCESSES + 1);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [FUNC_W-1:0] {
      FN_WRITE_MAX   = 3'd0,
      FN_WRITE_ALLOC = 3'd1,
      FN_WRITE_AVAIL = 3'd2,
      FN_REQUEST     = 3'd3,
      FN_SAFETY      = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EXCEEDS    = 3'd1,
      ST_NOT_AVAIL  = 3'd2,
      ST_UNSAFE     = 3'd3,
      ST_WRITE_DONE = 3'd4
   } rsp_status_type;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_REQUEST,
      KIND_SAFETY
   } req_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_CHECK,
      S_APPLY,
      S_INIT,
      S_SCAN,
      S_ROLLBACK,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic write;
      logic check;
      logic apply;
      logic init;
      logic scan;
      logic rollback;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         is_request;
      logic         check_pass;
      logic         scan_safe;
      logic         scan_unsafe;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/bankers_request_checker.sv
// channel   ports                                    direction  handshake
// request   req_func .. req_request_r3               in         start high, busy low
// result    rsp_status rsp_safe_order rsp_order_length out      rsp_strobe, one cycle
//
// writes and unknown funcs pass from S_WRITE to S_DONE, where the result is shown
// request: check, apply, init, scan of at most N passes of N processes (one process a
// cycle, resources compared in parallel), optional rollback
// safety check: init, then the same process scan as a request
// reset is synchronous, clears the controller; tables hold garbage until written
// the result is shown for one cycle and cannot be stalled
`default_nettype none

module bankers_request_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [brc_pkg::FUNC_W-1:0]       req_func,
   input  logic [brc_pkg::PIDX_PORT_W-1:0]  req_process_index,
   input  logic [brc_pkg::RIDX_PORT_W-1:0]  req_resource_index,
   input  logic [brc_pkg::FIELD_W-1:0]      req_write_value,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r0,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r1,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r2,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r3,
   output logic                             rsp_strobe,
   output logic [brc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [brc_pkg::ORDER_W-1:0]      rsp_safe_order,
   output logic [brc_pkg::LEN_W-1:0]        rsp_order_length
);
   import brc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   brc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   brc_datapath u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .stat               (stat),
      .req_func           (req_func),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_write_value    (req_write_value),
      .req_request_r0     (req_request_r0),
      .req_request_r1     (req_request_r1),
      .req_request_r2     (req_request_r2),
      .req_request_r3     (req_request_r3),
      .rsp_status         (rsp_status),
      .rsp_safe_order     (rsp_safe_order),
      .rsp_order_length   (rsp_order_length)
   );

endmodule

`default_nettype wire

// File: rtl/brc_ctrl.sv
`default_nettype none

module brc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output brc_pkg::dp_cmd_type cmd,
   input  brc_pkg::dp_stat_type stat
);
   import brc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (stat.kind)
                  KIND_REQUEST: state_in = S_CHECK;
                  KIND_SAFETY:  state_in = S_INIT;
                  default:      state_in = S_WRITE;
               endcase
            end
         end
         S_WRITE: state_in = S_DONE;
         S_CHECK: begin
            state_in = stat.check_pass ? S_APPLY : S_DONE;
         end
         S_APPLY: state_in = S_INIT;
         S_INIT:  state_in = S_SCAN;
         S_SCAN: begin
            if (stat.scan_safe) begin
               state_in = S_DONE;
            end else if (stat.scan_unsafe) begin
               state_in = stat.is_request ? S_ROLLBACK : S_DONE;
            end
         end
         S_ROLLBACK: state_in = S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         S_WRITE:    cmd.write    = 1'b1;
         S_CHECK:    cmd.check    = 1'b1;
         S_APPLY:    cmd.apply    = 1'b1;
         S_INIT:     cmd.init     = 1'b1;
         S_SCAN:     cmd.scan     = 1'b1;
         S_ROLLBACK: cmd.rollback = 1'b1;
         S_DONE:     rsp_strobe   = 1'b1;
         default:    busy         = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/brc_datapath.sv
`default_nettype none

module brc_datapath (
   input  logic                             clock,
   input  brc_pkg::dp_cmd_type              cmd,
   output brc_pkg::dp_stat_type             stat,
   input  logic [brc_pkg::FUNC_W-1:0]       req_func,
   input  logic [brc_pkg::PIDX_PORT_W-1:0]  req_process_index,
   input  logic [brc_pkg::RIDX_PORT_W-1:0]  req_resource_index,
   input  logic [brc_pkg::FIELD_W-1:0]      req_write_value,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r0,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r1,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r2,
   input  logic [brc_pkg::FIELD_W-1:0]      req_request_r3,
   output logic [brc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [brc_pkg::ORDER_W-1:0]      rsp_safe_order,
   output logic [brc_pkg::LEN_W-1:0]        rsp_order_length
);
   import brc_pkg::*;

   // latched request
   func_type                 func_ff;
   logic [PIDX_PORT_W-1:0]   pi_ff;
   logic [RIDX_PORT_W-1:0]   ri_ff;
   logic [FIELD_W-1:0]       wval_ff;
   logic [FIELD_W-1:0]       req_ff   [NUM_RESOURCES];
   logic [FIELD_W-1:0]       req_port [4];

   // tables
   count_type max_claim_ff [NUM_PROCESSES][NUM_RESOURCES];
   count_type alloc_ff     [NUM_PROCESSES][NUM_RESOURCES];
   count_type avail_ff     [NUM_RESOURCES];

   // safety scan
   logic [WORK_W-1:0]        work_ff [NUM_RESOURCES];
   logic [WORK_W-1:0]        work_in [NUM_RESOURCES];
   logic [NUM_PROCESSES-1:0] done_ff, done_in;
   logic [CNT_W-1:0]         count_ff, count_in, count_plus;
   logic [ORDER_W-1:0]       seq_ff, seq_in;
   logic                     found_ff, found_in;
   logic [PIDX_W-1:0]        scan_p_ff, scan_p_in;

   // result
   rsp_status_type           status_ff, status_in;
   logic [ORDER_W-1:0]       order_ff, order_in;
   logic [LEN_W-1:0]         length_ff, length_in;

   logic [PIDX_W-1:0]        pi_idx, rd_idx;
   logic [RIDX_W-1:0]        ri_idx;
   logic                     pi_ok, ri_ok;
   count_type                wval;
   count_type                row_max   [NUM_RESOURCES];
   count_type                row_alloc [NUM_RESOURCES];
   count_type                avail_sub [NUM_RESOURCES];
   count_type                avail_add [NUM_RESOURCES];
   count_type                alloc_add [NUM_RESOURCES];
   count_type                alloc_sub [NUM_RESOURCES];
   logic [CMP_W-1:0]         req_ext   [NUM_RESOURCES];
   logic signed [CMP_W-1:0]  need_cmp  [NUM_RESOURCES];
   logic signed [WORK_W:0]   need_w    [NUM_RESOURCES];
   logic [NUM_RESOURCES-1:0] exceeds, short_of, fits_r;
   rsp_status_type           check_code;
   logic                     bad_seen;
   logic                     fits, last_p;

   assign req_port[0] = req_request_r0;
   assign req_port[1] = req_request_r1;
   assign req_port[2] = req_request_r2;
   assign req_port[3] = req_request_r3;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff <= func_type'(req_func);
         pi_ff   <= req_process_index;
         ri_ff   <= req_resource_index;
         wval_ff <= req_write_value;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            req_ff[r] <= req_port[r];
         end
      end
   end

   always_comb begin
      unique case (func_type'(req_func))
         FN_REQUEST: stat.kind = KIND_REQUEST;
         FN_SAFETY:  stat.kind = KIND_SAFETY;
         default:    stat.kind = KIND_WRITE;
      endcase
   end

   assign pi_idx = pi_ff[PIDX_W-1:0];
   assign ri_idx = ri_ff[RIDX_W-1:0];
   assign pi_ok  = int'(pi_ff) < NUM_PROCESSES;
   assign ri_ok  = int'(ri_ff) < NUM_RESOURCES;
   assign rd_idx = cmd.scan ? scan_p_ff : pi_idx;
   assign wval   = COUNT_WIDTH'(CMP_W'(wval_ff));

   always_comb begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         row_max[r]   = max_claim_ff[rd_idx][r];
         row_alloc[r] = alloc_ff[rd_idx][r];
         req_ext[r]   = CMP_W'(req_ff[r]);
         need_cmp[r]  = $signed(CMP_W'(row_max[r]) - CMP_W'(row_alloc[r]));
         exceeds[r]   = $signed(req_ext[r]) > need_cmp[r];
         short_of[r]  = req_ext[r] > CMP_W'(avail_ff[r]);
         avail_sub[r] = COUNT_WIDTH'(CMP_W'(avail_ff[r]) - req_ext[r]);
         avail_add[r] = COUNT_WIDTH'(CMP_W'(avail_ff[r]) + req_ext[r]);
         alloc_add[r] = COUNT_WIDTH'(CMP_W'(row_alloc[r]) + req_ext[r]);
         alloc_sub[r] = COUNT_WIDTH'(CMP_W'(row_alloc[r]) - req_ext[r]);
         need_w[r]    = $signed((WORK_W+1)'(row_max[r]) - (WORK_W+1)'(row_alloc[r]));
         fits_r[r]    = need_w[r] <= $signed({1'b0, work_ff[r]});
      end
   end

   // first failing resource decides
   always_comb begin
      check_code = ST_OK;
      bad_seen   = 1'b0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         if (!bad_seen) begin
            if (exceeds[r]) begin
               check_code = ST_EXCEEDS;
               bad_seen   = 1'b1;
            end else if (short_of[r]) begin
               check_code = ST_NOT_AVAIL;
               bad_seen   = 1'b1;
            end
         end
      end
      if (!pi_ok) begin
         check_code = ST_EXCEEDS;
      end
   end

   assign stat.check_pass = (check_code == ST_OK);
   assign stat.is_request = (func_ff == FN_REQUEST);

   always_ff @(posedge clock) begin
      if (cmd.write && pi_ok && ri_ok) begin
         case (func_ff)
            FN_WRITE_MAX:   max_claim_ff[pi_idx][ri_idx] <= wval;
            FN_WRITE_ALLOC: alloc_ff[pi_idx][ri_idx]     <= wval;
            default: ;
         endcase
      end
      if (cmd.write && ri_ok && func_ff == FN_WRITE_AVAIL) begin
         avail_ff[ri_idx] <= wval;
      end
      if (cmd.apply) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            alloc_ff[pi_idx][r] <= alloc_add[r];
            avail_ff[r]         <= avail_sub[r];
         end
      end
      if (cmd.rollback) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            alloc_ff[pi_idx][r] <= alloc_sub[r];
            avail_ff[r]         <= avail_add[r];
         end
      end
   end

   assign fits       = !done_ff[scan_p_ff] && (&fits_r);
   assign last_p     = (int'(scan_p_ff) == NUM_PROCESSES - 1);
   assign count_plus = count_ff + CNT_W'(1);

   assign stat.scan_safe   = fits && (int'(count_plus) == NUM_PROCESSES);
   assign stat.scan_unsafe = last_p && !(found_ff || fits);

   always_comb begin
      work_in   = work_ff;
      done_in   = done_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      found_in  = found_ff;
      scan_p_in = scan_p_ff;
      if (cmd.init) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            work_in[r] = WORK_W'(avail_ff[r]);
         end
         done_in   = '0;
         count_in  = '0;
         seq_in    = '0;
         found_in  = 1'b0;
         scan_p_in = '0;
      end else if (cmd.scan) begin
         if (fits) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               work_in[r] = work_ff[r] + WORK_W'(row_alloc[r]);
            end
            done_in[scan_p_ff] = 1'b1;
            count_in           = count_plus;
            found_in           = 1'b1;
            for (int i = 0; i < NUM_PROCESSES; i++) begin
               if (int'(count_ff) == i) begin
                  seq_in[SLOT_W*i +: SLOT_W] = SLOT_W'(scan_p_ff);
               end
            end
         end
         if (last_p) begin
            scan_p_in = '0;
            found_in  = 1'b0;
         end else begin
            scan_p_in = scan_p_ff + PIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         work_ff[r] <= work_in[r];
      end
      done_ff   <= done_in;
      count_ff  <= count_in;
      seq_ff    <= seq_in;
      found_ff  <= found_in;
      scan_p_ff <= scan_p_in;
   end

   always_comb begin
      status_in = status_ff;
      order_in  = order_ff;
      length_in = length_ff;
      if (cmd.write) begin
         status_in = ST_WRITE_DONE;
         order_in  = '0;
         length_in = '0;
      end else if (cmd.check && !stat.check_pass) begin
         status_in = check_code;
         order_in  = '0;
         length_in = '0;
      end else if (cmd.scan) begin
         if (stat.scan_safe) begin
            status_in = ST_OK;
            order_in  = seq_in;
            length_in = LEN_W'(count_plus);
         end else if (stat.scan_unsafe) begin
            status_in = ST_UNSAFE;
            order_in  = '0;
            length_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      order_ff  <= order_in;
      length_ff <= length_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_safe_order   = order_ff;
   assign rsp_order_length = length_ff;

endmodule

`default_nettype wire

// File: rtl/brc_checker.sv
`default_nettype none

module brc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic [brc_pkg::STATUS_W-1:0] rsp_status,
   input logic [brc_pkg::ORDER_W-1:0]  rsp_safe_order,
   input logic [brc_pkg::LEN_W-1:0]    rsp_order_length
);
   import brc_pkg::*;

   // accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // non-success results carry no order; success places every process
   a_fail_no_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |->
         rsp_safe_order == '0 && rsp_order_length == '0)
      else $error("order reported with failing status");

   a_ok_full_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_OK |->
         rsp_order_length == LEN_W'(NUM_PROCESSES))
      else $error("safe result with short order");

endmodule

bind bankers_request_checker brc_checker u_brc_checker (.*);

`default_nettype wire

// File: bench/bankers_request_checker_tb.sv
`timescale 1ns / 100ps

module bankers_request_checker_tb;
   import brc_pkg::*;

   localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
   localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

   localparam int REQ_PORTS    = 4;
   localparam int TABLE_CELLS  = NUM_PROCESSES * NUM_RESOURCES;
   localparam int RANDOM_CMDS  = 1150;
   localparam int DRAIN_CYCLES = NUM_PROCESSES * NUM_PROCESSES + 16;
   localparam int MAX_PRINTED  = 100;

   localparam logic [0:TABLE_CELLS-1][FIELD_W-1:0] START_CLAIM = {
      8'd7, 8'd5, 8'd3, 8'd2,
      8'd3, 8'd2, 8'd2, 8'd1,
      8'd9, 8'd0, 8'd2, 8'd3,
      8'd2, 8'd2, 8'd2, 8'd2,
      8'd4, 8'd3, 8'd3, 8'd1
   };
   localparam logic [0:TABLE_CELLS-1][FIELD_W-1:0] START_ALLOC = {
      8'd0, 8'd1, 8'd0, 8'd0,
      8'd2, 8'd0, 8'd0, 8'd1,
      8'd3, 8'd0, 8'd2, 8'd1,
      8'd2, 8'd1, 8'd1, 8'd0,
      8'd0, 8'd0, 8'd2, 8'd1
   };
   localparam logic [0:NUM_RESOURCES-1][FIELD_W-1:0] START_AVAIL = {
      8'd3, 8'd3, 8'd2, 8'd2
   };

   typedef logic [REQ_PORTS-1:0][FIELD_W-1:0] unit_vec_t;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [PIDX_PORT_W-1:0] pidx;
      logic [RIDX_PORT_W-1:0] ridx;
      logic [FIELD_W-1:0]     value;
      unit_vec_t              units;
      logic [6:0]             gap_pct;
      logic                   wait_drain;
   } bank_cmd_t;

   typedef struct packed {
      rsp_status_type     status;
      logic [ORDER_W-1:0] order;
      logic [LEN_W-1:0]   length;
   } bank_rsp_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [FUNC_W-1:0]      req_func = '0;
   logic [PIDX_PORT_W-1:0] req_process_index = '0;
   logic [RIDX_PORT_W-1:0] req_resource_index = '0;
   logic [FIELD_W-1:0]     req_write_value = '0;
   logic [FIELD_W-1:0]     req_request_r0 = '0;
   logic [FIELD_W-1:0]     req_request_r1 = '0;
   logic [FIELD_W-1:0]     req_request_r2 = '0;
   logic [FIELD_W-1:0]     req_request_r3 = '0;
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic [ORDER_W-1:0]     rsp_safe_order;
   logic [LEN_W-1:0]       rsp_order_length;

   bankers_request_checker DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_write_value    (req_write_value),
      .req_request_r0     (req_request_r0),
      .req_request_r1     (req_request_r1),
      .req_request_r2     (req_request_r2),
      .req_request_r3     (req_request_r3),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_safe_order     (rsp_safe_order),
      .rsp_order_length   (rsp_order_length)
   );

   always #5 clock = ~clock;

   // predicted contents of the block's tables
   count_type claim_tbl [NUM_PROCESSES][NUM_RESOURCES];
   count_type alloc_tbl [NUM_PROCESSES][NUM_RESOURCES];
   count_type avail_tbl [NUM_RESOURCES];

   // what the stimulus generator believes was written, to aim requests
   int gen_claim [NUM_PROCESSES][NUM_RESOURCES];
   int gen_alloc [NUM_PROCESSES][NUM_RESOURCES];
   int gen_span = 6;

   bank_cmd_t queued_cmds[$];
   bank_rsp_t awaited_outcomes[$];
   bank_cmd_t live_cmd;
   int        mismatch_count = 0;
   int        outcome_index = 0;
   int        queued_total = 0;
   logic [6:0] cmd_gap = '0;
   logic       pause_next = 1'b0;

   function automatic bit find_safe_sequence(output logic [ORDER_W-1:0] seq,
                                             output logic [LEN_W-1:0] placed);
      int work [NUM_RESOURCES];
      bit finished [NUM_PROCESSES];
      bit progress;
      bit fits;
      int count;
      seq = '0;
      count = 0;
      for (int r = 0; r < NUM_RESOURCES; r++) work[r] = avail_tbl[r];
      for (int p = 0; p < NUM_PROCESSES; p++) finished[p] = 1'b0;
      progress = 1'b1;
      while (count < NUM_PROCESSES && progress) begin
         progress = 1'b0;
         for (int p = 0; p < NUM_PROCESSES; p++) begin
            if (!finished[p]) begin
               fits = 1'b1;
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  if (int'(claim_tbl[p][r]) - int'(alloc_tbl[p][r]) > work[r]) fits = 1'b0;
               end
               // later processes in the same pass see the released allocation
               if (fits) begin
                  for (int r = 0; r < NUM_RESOURCES; r++) work[r] += alloc_tbl[p][r];
                  finished[p] = 1'b1;
                  seq[SLOT_W*count +: SLOT_W] = SLOT_W'(p);
                  count++;
                  progress = 1'b1;
               end
            end
         end
      end
      placed = LEN_W'(count);
      return count == NUM_PROCESSES;
   endfunction

   function automatic bank_rsp_t bankers_outcome(input bank_cmd_t c);
      bank_rsp_t o;
      count_type kept_alloc [NUM_RESOURCES];
      count_type kept_avail [NUM_RESOURCES];
      logic [ORDER_W-1:0] seq;
      logic [LEN_W-1:0] placed;
      int p;
      int need;
      p = c.pidx;
      o.status = ST_WRITE_DONE;
      o.order = '0;
      o.length = '0;
      if (c.func == FN_WRITE_MAX || c.func == FN_WRITE_ALLOC) begin
         if (p < NUM_PROCESSES && c.ridx < NUM_RESOURCES) begin
            if (c.func == FN_WRITE_MAX) claim_tbl[p][c.ridx] = count_type'(c.value);
            else alloc_tbl[p][c.ridx] = count_type'(c.value);
         end
      end else if (c.func == FN_WRITE_AVAIL) begin
         if (c.ridx < NUM_RESOURCES) avail_tbl[c.ridx] = count_type'(c.value);
      end else if (c.func == FN_REQUEST) begin
         if (p >= NUM_PROCESSES) begin
            o.status = ST_EXCEEDS;
         end else begin
            o.status = ST_OK;
            // first failing resource decides, claim tested before availability
            for (int r = 0; r < NUM_RESOURCES && o.status == ST_OK; r++) begin
               need = int'(claim_tbl[p][r]) - int'(alloc_tbl[p][r]);
               if (int'(c.units[r]) > need) o.status = ST_EXCEEDS;
               else if (c.units[r] > avail_tbl[r]) o.status = ST_NOT_AVAIL;
            end
         end
         if (o.status == ST_OK) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               kept_alloc[r] = alloc_tbl[p][r];
               kept_avail[r] = avail_tbl[r];
               avail_tbl[r] = avail_tbl[r] - c.units[r];
               alloc_tbl[p][r] = alloc_tbl[p][r] + c.units[r];
            end
            if (find_safe_sequence(seq, placed)) begin
               o.order = seq;
               o.length = placed;
            end else begin
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  alloc_tbl[p][r] = kept_alloc[r];
                  avail_tbl[r] = kept_avail[r];
               end
               o.status = ST_UNSAFE;
            end
         end
      end else if (c.func == FN_SAFETY) begin
         if (find_safe_sequence(seq, placed)) begin
            o.status = ST_OK;
            o.order = seq;
            o.length = placed;
         end else begin
            o.status = ST_UNSAFE;
         end
      end
      if (o.status != ST_OK) begin
         o.order = '0;
         o.length = '0;
      end
      return o;
   endfunction

   task automatic report_mismatch(input string detail);
      if (mismatch_count < MAX_PRINTED) $display("mismatch at %0t: %s", $time, detail);
      mismatch_count++;
   endtask

   function automatic unit_vec_t units4(input int a, input int b, input int c, input int d);
      return {FIELD_W'(d), FIELD_W'(c), FIELD_W'(b), FIELD_W'(a)};
   endfunction

   task automatic push_cmd(input logic [FUNC_W-1:0] func, input logic [PIDX_PORT_W-1:0] pidx,
                           input logic [RIDX_PORT_W-1:0] ridx, input logic [FIELD_W-1:0] value,
                           input unit_vec_t units);
      bank_cmd_t c;
      c.func = func;
      c.pidx = pidx;
      c.ridx = ridx;
      c.value = value;
      c.units = units;
      c.gap_pct = cmd_gap;
      c.wait_drain = pause_next;
      pause_next = 1'b0;
      if (pidx < NUM_PROCESSES && ridx < NUM_RESOURCES) begin
         if (func == FN_WRITE_MAX) gen_claim[pidx][ridx] = value;
         if (func == FN_WRITE_ALLOC) gen_alloc[pidx][ridx] = value;
      end
      queued_cmds.push_back(c);
      queued_total++;
   endtask

   task automatic reload_tables();
      int claim;
      case ($urandom_range(0, 3))
         0: gen_span = 2;
         1: gen_span = 6;
         2: gen_span = 25;
         default: gen_span = 255;
      endcase
      for (int p = 0; p < NUM_PROCESSES; p++) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            claim = $urandom_range(0, gen_span);
            push_cmd(FN_WRITE_MAX, p, r, claim, $urandom());
            // now and then an allocation above the claim
            if ($urandom_range(0, 9) == 0)
               push_cmd(FN_WRITE_ALLOC, p, r, $urandom_range(0, gen_span), $urandom());
            else
               push_cmd(FN_WRITE_ALLOC, p, r, $urandom_range(0, claim), $urandom());
         end
      end
      for (int r = 0; r < NUM_RESOURCES; r++)
         push_cmd(FN_WRITE_AVAIL, $urandom_range(0, 7), r, $urandom_range(0, gen_span),
                  $urandom());
   endtask

   task automatic push_random_request();
      int p;
      int head;
      unit_vec_t u;
      if ($urandom_range(0, 7) == 0) begin
         push_cmd(FN_REQUEST, $urandom_range(0, 7), $urandom_range(0, 3), $urandom(),
                  $urandom());
      end else begin
         p = $urandom_range(0, NUM_PROCESSES - 1);
         u = '0;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            head = gen_claim[p][r] - gen_alloc[p][r];
            if (head > 0 && $urandom_range(0, 1) == 1) u[r] = $urandom_range(0, head);
         end
         push_cmd(FN_REQUEST, p, $urandom_range(0, 3), $urandom(), u);
      end
   endtask

   // driver
   always @(posedge clock) begin
      bit hold;
      bit go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         hold = start && busy;
         if (start && !busy) awaited_outcomes.push_back(bankers_outcome(live_cmd));
         if (!hold) begin
            go = 1'b0;
            if (queued_cmds.size() > 0) begin
               if (queued_cmds[0].wait_drain)
                  go = (awaited_outcomes.size() == 0) && (busy === 1'b0);
               else
                  go = $urandom_range(0, 99) >= queued_cmds[0].gap_pct;
            end
            if (go) begin
               live_cmd = queued_cmds.pop_front();
               req_func <= live_cmd.func;
               req_process_index <= live_cmd.pidx;
               req_resource_index <= live_cmd.ridx;
               req_write_value <= live_cmd.value;
               req_request_r0 <= live_cmd.units[0];
               req_request_r1 <= live_cmd.units[1];
               req_request_r2 <= live_cmd.units[2];
               req_request_r3 <= live_cmd.units[3];
            end
            start <= go;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bank_rsp_t want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, status %0d", rsp_status));
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                         outcome_index, rsp_status, want.status));
            if (rsp_safe_order !== want.order)
               report_mismatch($sformatf("result %0d safe_order %06h, predicted %06h",
                                         outcome_index, rsp_safe_order, want.order));
            if (rsp_order_length !== want.length)
               report_mismatch($sformatf("result %0d order_length %0d, predicted %0d",
                                         outcome_index, rsp_order_length, want.length));
         end
         outcome_index++;
      end
   end

   initial begin
      int burst;
      int pick;
      int phase;
      int last_phase;
      int random_base;

      // every table entry written before anything reads it
      for (int p = 0; p < NUM_PROCESSES; p++) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            push_cmd(FN_WRITE_MAX, p, r, START_CLAIM[p*NUM_RESOURCES+r], $urandom());
            push_cmd(FN_WRITE_ALLOC, p, r, START_ALLOC[p*NUM_RESOURCES+r], $urandom());
            gen_claim[p][r] = START_CLAIM[p*NUM_RESOURCES+r];
            gen_alloc[p][r] = START_ALLOC[p*NUM_RESOURCES+r];
         end
      end
      for (int r = 0; r < NUM_RESOURCES; r++)
         push_cmd(FN_WRITE_AVAIL, 0, r, START_AVAIL[r], $urandom());

      // directed
      push_cmd(FN_SAFETY, 0, 0, 0, '0);
      push_cmd(FN_REQUEST, 1, 0, 0, units4(1, 0, 2, 0));
      push_cmd(FN_REQUEST, 0, 0, 0, units4(0, 5, 0, 0));
      // not available on resource 0 wins over exceeds claim on resource 1
      push_cmd(FN_REQUEST, 4, 0, 0, units4(4, 9, 0, 0));
      push_cmd(FN_REQUEST, 0, 0, 0, units4(2, 0, 0, 0));
      // absent processes
      push_cmd(FN_REQUEST, 5, 0, 0, units4(0, 0, 0, 0));
      push_cmd(FN_REQUEST, 7, 3, 8'd255, units4(255, 255, 255, 255));
      push_cmd(FN_WRITE_MAX, 5, 3, 8'd255, '0);
      push_cmd(FN_WRITE_ALLOC, 7, 0, 8'd255, '1);
      // unknown funcs
      push_cmd(FN_SPARE_5, 7, 3, 8'd255, '1);
      push_cmd(FN_SPARE_6, 2, 1, $urandom(), $urandom());
      push_cmd(FN_SPARE_7, 0, 0, 8'd0, '0);
      // allocation above claim, large work sums
      push_cmd(FN_WRITE_ALLOC, 4, 0, 8'd255, '0);
      push_cmd(FN_SAFETY, 0, 0, 0, '0);
      push_cmd(FN_REQUEST, 4, 0, 0, units4(0, 0, 0, 0));
      push_cmd(FN_REQUEST, 2, 0, 0, units4(255, 255, 255, 255));
      push_cmd(FN_REQUEST, 2, 0, 0, units4(0, 0, 0, 0));
      push_cmd(FN_WRITE_AVAIL, 0, 1, 8'd0, '0);
      push_cmd(FN_WRITE_AVAIL, 0, 2, 8'd0, '0);
      push_cmd(FN_SAFETY, 0, 0, 0, '0);
      push_cmd(FN_WRITE_MAX, 3, 2, 8'd255, '0);
      push_cmd(FN_SAFETY, 0, 0, 0, '0);
      push_cmd(FN_REQUEST, 3, 0, 0, units4(0, 0, 1, 0));
      gen_alloc[4][0] = 255;
      gen_claim[3][2] = 255;

      // random
      random_base = queued_total;
      last_phase = -1;
      while (queued_total < random_base + RANDOM_CMDS) begin
         phase = (queued_total - random_base) * 4 / RANDOM_CMDS;
         if (phase != last_phase) begin
            case (phase)
               1: cmd_gap = 7'd83;
               3: cmd_gap = 7'd19;
               default: cmd_gap = 7'd0;
            endcase
            pause_next = 1'b1;
            last_phase = phase;
         end
         if ($urandom_range(0, 4) == 0) begin
            reload_tables();
         end else begin
            repeat ($urandom_range(0, 3))
               push_cmd($urandom_range(FN_WRITE_MAX, FN_WRITE_AVAIL),
                        $urandom_range(0, NUM_PROCESSES - 1),
                        $urandom_range(0, NUM_RESOURCES - 1),
                        $urandom_range(0, gen_span), $urandom());
         end
         burst = $urandom_range(8, 20);
         repeat (burst) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               push_random_request();
            else if (pick < 80)
               push_cmd(FN_SAFETY, $urandom_range(0, 7), $urandom_range(0, 3), $urandom(),
                        $urandom());
            else
               push_cmd($urandom_range(FN_WRITE_MAX, FN_SPARE_7), $urandom_range(0, 7),
                        $urandom_range(0, 3), $urandom(), $urandom());
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (queued_cmds.size() > 0 || start) @(posedge clock);
      while (awaited_outcomes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
